// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; included by the top-level binarizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OTSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/otsu_pkg.sv =====
// Shared constants for the Otsu threshold binarizer.
package otsu_pkg;
    localparam int LEVELS     = 256;
    localparam int LVL_W      = 8;
    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 29;
    localparam int HIST_W     = 21;
    localparam int THR_W      = 9;
    localparam int D_W        = SUM_W + CNT_W;
    localparam int DEN_W      = 2 * CNT_W;
    localparam int SQ_W       = 2 * D_W;
    localparam int MUL_A_W    = SQ_W;
    localparam int MUL_B_W    = D_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W    = 4;

    localparam logic CMD_HIST = 1'b0;
    localparam logic CMD_BIN  = 1'b1;
    localparam logic KIND_THR = 1'b0;
    localparam logic KIND_PIX = 1'b1;
endpackage

// ===== hw/rtl/otsu_mul.sv =====
// Digit-serial multiplier, DIGIT_W multiplier bits per cycle.
module otsu_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [otsu_pkg::MUL_A_W-1:0] op_a,
    input  logic [otsu_pkg::MUL_B_W-1:0] op_b,
    output logic                        done,
    output logic [otsu_pkg::PROD_W-1:0]  product
);
    import otsu_pkg::*;

    logic [PROD_W-1:0]  mcand_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [MUL_B_W-1:0] mplier_reg;
    logic               busy_reg;
    logic [PROD_W-1:0]  partial;

    assign partial = mcand_reg * PROD_W'(mplier_reg[DIGIT_W-1:0]);
    // finishes once the remaining multiplier digits are all zero
    assign done    = busy_reg && (mplier_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= PROD_W'(op_a);
            mplier_reg <= op_b;
            acc_reg    <= '0;
        end else if (busy_reg && (mplier_reg != '0)) begin
            acc_reg    <= acc_reg + partial;
            mcand_reg  <= mcand_reg << DIGIT_W;
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end
endmodule

// ===== hw/rtl/otsu_threshold_binarizer.sv =====
// Otsu threshold binarizer top level: histogram memory, sweep sequencer, stream ports.
//
// Input beats (s_*): tuser is the command (0 histogram, 1 binarize), tdata[7:0] the
// pixel, tlast marks the final histogram pixel of a frame. Output beats (m_*): tuser
// is the kind (0 threshold report, 1 binarized pixel), tdata holds binary_pixel,
// threshold and count_overflow. The user writes max_value on the cfg_* channel only
// when idle; the block does not enforce it. Histogram and binarize beats are taken
// one per cycle; the histogram memory is read when a histogram pixel is counted and
// written back the next cycle, with a one-entry forward covering back-to-back hits
// on the same bin. A binarized pixel appears on m_* in the cycle after its beat is
// taken. The tlast pixel starts a sweep over the levels below max_value: each level
// passes the read, accumulate and check states, then up to six products of the shared
// 4-bit-per-cycle multiplier; the report follows the sweep. Input is not taken during
// the sweep or while the output register is full and stalled by m_tready. Reset
// clears the bin valid bits at once (no clearing pass), the count, the sum and the
// overflow flag, sets the threshold to -1 and max_value to 255.
module otsu_threshold_binarizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] binary_pixel, [16:8] threshold, [17] count_overflow
    output logic        m_tuser,   // [0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import otsu_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_DRAIN   = 12'b0000_0000_0010,
        ST_SW_RD   = 12'b0000_0000_0100,
        ST_SW_ACC  = 12'b0000_0000_1000,
        ST_SW_CHK  = 12'b0000_0001_0000,
        ST_MUL_A   = 12'b0000_0010_0000,
        ST_MUL_B   = 12'b0000_0100_0000,
        ST_MUL_DEN = 12'b0000_1000_0000,
        ST_MUL_SQ  = 12'b0001_0000_0000,
        ST_MUL_L   = 12'b0010_0000_0000,
        ST_MUL_R   = 12'b0100_0000_0000,
        ST_REPORT  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [HIST_W-1:0] hist_mem [LEVELS];
    logic [LEVELS-1:0] hist_vld_reg;
    logic [HIST_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              st1_vld_reg;
    logic [LVL_W-1:0]  st1_addr_reg;
    logic              fwd_hit_reg;
    logic [HIST_W-1:0] fwd_data_reg;

    logic [7:0]        max_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              ovf_reg;
    logic signed [THR_W-1:0] thr_reg;

    logic [THR_W-1:0]  lvl_reg, lvl_next;
    logic [CNT_W-1:0]  q_reg, q_next;
    logic [SUM_W-1:0]  s_reg, s_next;
    logic [D_W-1:0]    a_reg;
    logic [D_W-1:0]    d_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [SQ_W-1:0]   best_sq_reg;
    logic [DEN_W-1:0]  best_den_reg;
    logic              have_reg;
    logic signed [THR_W-1:0] cand_thr_reg;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic              m_tuser_reg;

    logic              out_free;
    logic              s_acc;
    logic              hist_acc;
    logic              hist_counted;
    logic              bin_acc;
    logic [LVL_W-1:0]  pix_clamped;
    logic [LVL_W-1:0]  rd_addr;
    logic              rd_en;
    logic [HIST_W-1:0] hist_new;
    logic [HIST_W-1:0] bin_h;
    logic              report_load;
    logic [7:0]        bin_out;

    logic                 mul_start;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_done;
    logic [PROD_W-1:0]    mul_prod;
    logic [D_W-1:0]       b_val;

    otsu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign s_acc        = s_tvalid && s_tready;
    assign hist_acc     = s_acc && (s_tuser == CMD_HIST);
    assign bin_acc      = s_acc && (s_tuser == CMD_BIN);
    assign hist_counted = hist_acc && (count_reg < CNT_W'(MAX_PIXELS));
    assign pix_clamped  = (s_tdata > max_reg) ? max_reg : s_tdata;
    assign bin_out      = ($signed({1'b0, pix_clamped}) > thr_reg) ? max_reg : 8'd0;
    assign report_load  = (state_reg == ST_REPORT) && out_free;
    assign cfg_ready    = 1'b1;

    assign rd_en    = hist_counted || (state_reg == ST_SW_RD);
    assign rd_addr  = (state_reg == ST_SW_RD) ? lvl_reg[LVL_W-1:0] : pix_clamped;
    assign hist_new = (fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0)) + 1'b1;
    assign bin_h    = rd_vld_reg ? rd_data_reg : '0;
    assign b_val    = mul_prod[D_W-1:0];

    // histogram memory: one read and one write port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
        if (st1_vld_reg) begin
            hist_mem[st1_addr_reg] <= hist_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_reg <= hist_vld_reg[rd_addr];
        end
        st1_addr_reg <= pix_clamped;
        fwd_data_reg <= hist_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            st1_vld_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            st1_vld_reg <= hist_counted;
            // previous bin write lands at this edge, after this read
            fwd_hit_reg <= hist_counted && st1_vld_reg && (st1_addr_reg == pix_clamped);
            if (report_load) begin
                hist_vld_reg <= '0;
            end else if (st1_vld_reg) begin
                hist_vld_reg[st1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= 8'd255;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            thr_reg   <= '1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
            if (report_load) begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
                thr_reg   <= cand_thr_reg;
            end else if (hist_counted) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(pix_clamped);
            end else if (hist_acc) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_SW_CHK: begin
                mul_start = (q_reg != '0) && (q_reg < count_reg);
                mul_a     = MUL_A_W'(sum_reg);
                mul_b     = MUL_B_W'(q_reg);
            end
            ST_MUL_A: begin
                mul_start = mul_done;
                mul_a     = MUL_A_W'(s_reg);
                mul_b     = MUL_B_W'(count_reg);
            end
            ST_MUL_B: begin
                mul_start = mul_done;
                mul_a     = MUL_A_W'(q_reg);
                mul_b     = MUL_B_W'(count_reg - q_reg);
            end
            ST_MUL_DEN: begin
                mul_start = mul_done && (d_reg != '0);
                mul_a     = MUL_A_W'(d_reg);
                mul_b     = MUL_B_W'(d_reg);
            end
            ST_MUL_SQ: begin
                mul_start = mul_done && have_reg;
                mul_a     = MUL_A_W'(mul_prod[SQ_W-1:0]);
                mul_b     = MUL_B_W'(best_den_reg);
            end
            ST_MUL_L: begin
                mul_start = mul_done;
                mul_a     = MUL_A_W'(best_sq_reg);
                mul_b     = MUL_B_W'(den_reg);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        q_next     = q_reg;
        s_next     = s_reg;
        case (state_reg)
            ST_IDLE: begin
                if (hist_acc && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SW_RD;
                lvl_next   = '0;
                q_next     = '0;
                s_next     = '0;
            end
            ST_SW_RD: begin
                state_next = (lvl_reg >= THR_W'(max_reg)) ? ST_REPORT : ST_SW_ACC;
            end
            ST_SW_ACC: begin
                q_next     = q_reg + CNT_W'(bin_h);
                s_next     = s_reg + SUM_W'(lvl_reg[LVL_W-1:0] * bin_h);
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK: begin
                if (mul_start) begin
                    state_next = ST_MUL_A;
                end else begin
                    state_next = ST_SW_RD;
                    lvl_next   = lvl_reg + 1'b1;
                end
            end
            ST_MUL_A: begin
                if (mul_done) begin
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mul_done) begin
                    state_next = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN: begin
                if (mul_done) begin
                    if (d_reg != '0) begin
                        state_next = ST_MUL_SQ;
                    end else begin
                        state_next = ST_SW_RD;
                        lvl_next   = lvl_reg + 1'b1;
                    end
                end
            end
            ST_MUL_SQ: begin
                if (mul_done) begin
                    if (have_reg) begin
                        state_next = ST_MUL_L;
                    end else begin
                        state_next = ST_SW_RD;
                        lvl_next   = lvl_reg + 1'b1;
                    end
                end
            end
            ST_MUL_L: begin
                if (mul_done) begin
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                if (mul_done) begin
                    state_next = ST_SW_RD;
                    lvl_next   = lvl_reg + 1'b1;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            have_reg     <= 1'b0;
            cand_thr_reg <= '1;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DRAIN) begin
                have_reg     <= 1'b0;
                cand_thr_reg <= '1;
            end else if (state_reg == ST_MUL_SQ && mul_done && !have_reg) begin
                have_reg     <= 1'b1;
                cand_thr_reg <= $signed(lvl_reg);
            end else if (state_reg == ST_MUL_R && mul_done && (lhs_reg > mul_prod)) begin
                cand_thr_reg <= $signed(lvl_reg);
            end
        end
    end

    // sweep datapath
    always_ff @(posedge aclk) begin
        lvl_reg <= lvl_next;
        q_reg   <= q_next;
        s_reg   <= s_next;
        if (state_reg == ST_MUL_A && mul_done) begin
            a_reg <= mul_prod[D_W-1:0];
        end
        if (state_reg == ST_MUL_B && mul_done) begin
            d_reg <= (a_reg >= b_val) ? (a_reg - b_val) : (b_val - a_reg);
        end
        if (state_reg == ST_MUL_DEN && mul_done) begin
            den_reg <= mul_prod[DEN_W-1:0];
        end
        if (state_reg == ST_MUL_SQ && mul_done) begin
            sq_reg <= mul_prod[SQ_W-1:0];
            if (!have_reg) begin
                best_sq_reg  <= mul_prod[SQ_W-1:0];
                best_den_reg <= den_reg;
            end
        end
        if (state_reg == ST_MUL_L && mul_done) begin
            lhs_reg <= mul_prod;
        end
        if (state_reg == ST_MUL_R && mul_done && (lhs_reg > mul_prod)) begin
            best_sq_reg  <= sq_reg;
            best_den_reg <= den_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (bin_acc || report_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (bin_acc) begin
            m_tdata_reg <= {6'd0, 1'b0, thr_reg, bin_out};
            m_tuser_reg <= KIND_PIX;
        end else if (report_load) begin
            m_tdata_reg <= {6'd0, ovf_reg, cand_thr_reg, 8'd0};
            m_tuser_reg <= KIND_THR;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "assert_macros.svh"

    `OTSU_ASSERT_NOW(a_pix_no_ovf, m_tvalid && (m_tuser == KIND_PIX), m_tdata[17] == 1'b0,
        "binarized beat carries overflow flag")
    `OTSU_ASSERT_NEXT(a_report_clears, report_load,
        (count_reg == '0) && (hist_vld_reg == '0) && !ovf_reg,
        "histogram state not cleared after report")
    `OTSU_ASSERT_NOW(a_fwd_needs_write, fwd_hit_reg, st1_vld_reg,
        "forward hit without a pending bin write")
    `OTSU_ASSERT_NOW(a_mul_only_sweep, mul_start,
        (state_reg != ST_IDLE) && (state_reg != ST_REPORT),
        "multiplier started outside the sweep")
endmodule
